### rtl/kmeans_color_quantizer_top_defines.svh
// Assertion macros for the colour quantizer top level.
// Needs signals clk and arst_n in the scope of each use.
`ifndef KMEANS_COLOR_QUANTIZER_TOP_DEFINES_SVH
`define KMEANS_COLOR_QUANTIZER_TOP_DEFINES_SVH

// same-cycle implication
`define KCQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kcq check failed");

// next-cycle implication
`define KCQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kcq check failed");

`endif

### rtl/kcq_pkg.sv
// Shared types and constants for the k-means colour quantizer.
// No dependencies.
`default_nettype none
package kcq_pkg;
	localparam int DEF_MAX_PIXELS   = 65536;
	localparam int DEF_MAX_CLUSTERS = 16;
	localparam int DIST_W           = 18;
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 3 + 1);
	localparam logic [4:0]  CLUSTERS_RESET = 5'd8;
	localparam logic [16:0] PIXELS_RESET   = 17'd65536;
	localparam logic [6:0]  ITER_RESET     = 7'd100;
	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_LABEL   = 1'b1;

	typedef enum logic [1:0] {
		FUNC_LOAD_PIXEL  = 2'd0,
		FUNC_LOAD_CENTER = 2'd1,
		FUNC_RUN         = 2'd2,
		FUNC_READ_LABEL  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_CLUSTERS = 2'd0,
		CFG_PIXELS   = 2'd1,
		CFG_ITER     = 2'd2,
		CFG_SPARE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] entry;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] passes;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load_pix;
		logic load_cen;
		logic rd_label_in;
		logic lim_set;
		logic lim_zero;
		logic acc_clear;
		logic pix_rd;
		logic best_init;
		logic dist_en;
		logic lbl_wr;
		logic acc_rd;
		logic acc_upd;
		logic acc_wr;
		logic div_load;
		logic div_step;
		logic cen_upd;
		logic out_pal;
		logic out_lbl;
		logic out_last;
	} kcq_cmd_t;

	typedef struct packed {
		logic label_diff;
		logic div_zero;
		logic out_free;
	} kcq_sts_t;
endpackage
`default_nettype wire

### rtl/kcq_datapath.sv
// Datapath: pixel, label and accumulator memories, centre registers,
// distance unit, restoring divider and result register. Uses kcq_pkg.
`default_nettype none
module kcq_datapath #(
	parameter int MAX_PIXELS   = kcq_pkg::DEF_MAX_PIXELS,
	parameter int MAX_CLUSTERS = kcq_pkg::DEF_MAX_CLUSTERS,
	localparam int PIX_AW = $clog2(MAX_PIXELS),
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1),
	localparam int CIX_W  = $clog2(MAX_CLUSTERS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kcq_pkg::in_item_t in_item,
	input  wire kcq_pkg::kcq_cmd_t cmd,
	output kcq_pkg::kcq_sts_t      sts,
	input  wire logic [PIX_AW-1:0] pix_idx,
	input  wire logic [CIX_W-1:0]  cen_idx,
	input  wire logic [CIX_W-1:0]  upd_idx,
	input  wire logic [2:0]        div_bit,
	input  wire logic [7:0]        pass_val,
	input  wire logic [CNT_W-1:0]  n_eff,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kcq_pkg::out_item_t     out_item
);
	import kcq_pkg::*;

	localparam int SUM_W = CNT_W + 8;
	localparam int ACC_W = 3 * SUM_W + CNT_W;

	logic [23:0] pix_mem [MAX_PIXELS];
	logic [CIX_W-1:0] label_mem [MAX_PIXELS];
	logic [ACC_W-1:0] acc_mem [MAX_CLUSTERS];
	logic [23:0] cen_q [MAX_CLUSTERS];

	logic [23:0] pix_rd_q;
	logic [CIX_W-1:0] lbl_rd_q;
	logic lbl_ok_q;
	logic [CNT_W-1:0] lim_q;
	logic [DIST_W-1:0] best_d_q;
	logic [CIX_W-1:0] best_q;
	logic [ACC_W-1:0] acc_rd_q;
	logic acc_vrd_q;
	logic [MAX_CLUSTERS-1:0] vld_q;
	logic [SUM_W-1:0] rem_q [3];
	logic [CNT_W-1:0] dcnt_q;
	logic [7:0] quo_q [3];
	logic out_valid_q;
	out_item_t out_q;

	logic [PIX_AW-1:0] lbl_addr;
	logic [CIX_W-1:0] acc_addr;
	logic [23:0] cen_rd;
	logic signed [8:0] df [3];
	logic signed [17:0] sq [3];
	logic [DIST_W-1:0] sq_dist;
	logic [ACC_W-1:0] acc_base;
	logic [ACC_W-1:0] acc_new;
	logic [SUM_W-1:0] div_sh;
	logic pix_in_range;
	logic cen_in_range;

	assign pix_in_range = 32'(in_item.index) < MAX_PIXELS;
	assign cen_in_range = 32'(in_item.index) < MAX_CLUSTERS;
	assign lbl_addr = cmd.rd_label_in ? PIX_AW'(in_item.index) : pix_idx;
	assign acc_addr = cmd.acc_upd ? upd_idx : best_q;
	assign cen_rd   = cen_q[cen_idx];

	// squared RGB distance to the selected centre
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			df[c] = $signed({1'b0, cen_rd[23-8*c -: 8]}) - $signed({1'b0, pix_rd_q[23-8*c -: 8]});
			sq[c] = df[c] * df[c];
		end
		sq_dist = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
	end

	// accumulate the pixel into its cluster; an invalid entry reads as zero
	always_comb begin
		acc_base = acc_vrd_q ? acc_rd_q : '0;
		for (int c = 0; c < 3; c++) begin
			acc_new[ACC_W-1-c*SUM_W -: SUM_W] = acc_base[ACC_W-1-c*SUM_W -: SUM_W]
				+ SUM_W'(pix_rd_q[23-8*c -: 8]);
		end
		acc_new[CNT_W-1:0] = acc_base[CNT_W-1:0] + CNT_W'(1);
	end

	assign div_sh = SUM_W'(dcnt_q) << div_bit;

	always_ff @(posedge clk) begin
		if (cmd.load_pix && pix_in_range)
			pix_mem[PIX_AW'(in_item.index)] <= {in_item.red, in_item.green, in_item.blue};
		if (cmd.pix_rd)
			pix_rd_q <= pix_mem[pix_idx];
		if (cmd.lbl_wr)
			label_mem[pix_idx] <= best_q;
		if (cmd.rd_label_in || cmd.pix_rd)
			lbl_rd_q <= label_mem[lbl_addr];
		if (cmd.acc_wr)
			acc_mem[best_q] <= acc_new;
		if (cmd.acc_rd)
			acc_rd_q <= acc_mem[acc_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cen && cen_in_range)
			cen_q[CIX_W'(in_item.index)] <= {in_item.red, in_item.green, in_item.blue};
		else if (cmd.cen_upd)
			cen_q[upd_idx] <= {quo_q[0], quo_q[1], quo_q[2]};
		if (cmd.best_init) begin
			best_d_q <= DIST_START;
			best_q   <= '0;
		end else if (cmd.dist_en && sq_dist < best_d_q) begin
			best_d_q <= sq_dist;
			best_q   <= cen_idx;
		end
		if (cmd.acc_rd)
			acc_vrd_q <= vld_q[acc_addr];
		if (cmd.rd_label_in)
			lbl_ok_q <= 32'(in_item.index) < 32'(lim_q);
		if (cmd.div_load) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= acc_rd_q[ACC_W-1-c*SUM_W -: SUM_W];
				quo_q[c] <= '0;
			end
			dcnt_q <= acc_rd_q[CNT_W-1:0];
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= div_sh) begin
					rem_q[c] <= rem_q[c] - div_sh;
					quo_q[c][div_bit] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			lim_q <= '0;
		end else begin
			if (cmd.acc_clear)
				vld_q <= '0;
			else if (cmd.acc_wr)
				vld_q[best_q] <= 1'b1;
			if (cmd.lim_set)
				lim_q <= cmd.lim_zero ? '0 : n_eff;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_pal || cmd.out_lbl)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_pal) begin
			out_q.kind      <= KIND_PALETTE;
			out_q.entry     <= 4'(cen_idx);
			out_q.out_red   <= cen_rd[23:16];
			out_q.out_green <= cen_rd[15:8];
			out_q.out_blue  <= cen_rd[7:0];
			out_q.passes    <= pass_val;
			out_q.last      <= cmd.out_last;
		end else if (cmd.out_lbl) begin
			out_q.kind      <= KIND_LABEL;
			out_q.entry     <= lbl_ok_q ? 4'(lbl_rd_q) : 4'd0;
			out_q.out_red   <= 8'd0;
			out_q.out_green <= 8'd0;
			out_q.out_blue  <= 8'd0;
			out_q.passes    <= 8'd0;
			out_q.last      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign sts.label_diff = lbl_rd_q != best_q;
	assign sts.div_zero   = !acc_vrd_q || (acc_rd_q[CNT_W-1:0] == '0);
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

### rtl/kcq_ctrl.sv
// Sequencer for loads, label reads, Lloyd passes, centre update and
// palette output. Drives kcq_datapath through kcq_pkg command types.
`default_nettype none
module kcq_ctrl #(
	parameter int MAX_PIXELS   = kcq_pkg::DEF_MAX_PIXELS,
	parameter int MAX_CLUSTERS = kcq_pkg::DEF_MAX_CLUSTERS,
	localparam int PIX_AW = $clog2(MAX_PIXELS),
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1),
	localparam int CIX_W  = $clog2(MAX_CLUSTERS),
	localparam int CLU_W  = $clog2(MAX_CLUSTERS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire kcq_pkg::func_t    in_func,
	input  wire logic [CLU_W-1:0]  k_eff,
	input  wire logic [CNT_W-1:0]  n_eff,
	input  wire logic [6:0]        max_iter,
	input  wire kcq_pkg::kcq_sts_t sts,
	output kcq_pkg::kcq_cmd_t      cmd,
	output logic [PIX_AW-1:0]      pix_idx,
	output logic [CIX_W-1:0]       cen_idx,
	output logic [CIX_W-1:0]       upd_idx,
	output logic [2:0]             div_bit,
	output logic [7:0]             pass_val
);
	import kcq_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_LOUT   = 15'h0002,
		S_RSTART = 15'h0004,
		S_PSTART = 15'h0008,
		S_PREAD  = 15'h0010,
		S_PLATCH = 15'h0020,
		S_PDIST  = 15'h0040,
		S_PWRITE = 15'h0080,
		S_PACC   = 15'h0100,
		S_PEND   = 15'h0200,
		S_UREAD  = 15'h0400,
		S_ULOAD  = 15'h0800,
		S_UDIV   = 15'h1000,
		S_UWRITE = 15'h2000,
		S_EMIT   = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] p_q, p_d;
	logic [CIX_W-1:0] ci_q, ci_d, u_q, u_d, e_q, e_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] pass_q, pass_d;
	logic chg_q, chg_d;
	logic [CLU_W-1:0] k_last;
	logic u_last;
	logic stop_iter;

	assign k_last    = k_eff - CLU_W'(1);
	assign u_last    = CLU_W'(u_q) == k_last;
	assign stop_iter = 8'(pass_q + 8'd1) > 8'(max_iter);

	always_comb begin
		state_d = state_q;
		p_d = p_q; ci_d = ci_q; u_d = u_q; e_d = e_q;
		bit_d = bit_q; pass_d = pass_q; chg_d = chg_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_func)
						FUNC_LOAD_PIXEL:  cmd.load_pix = 1'b1;
						FUNC_LOAD_CENTER: cmd.load_cen = 1'b1;
						FUNC_READ_LABEL: begin
							cmd.rd_label_in = 1'b1;
							state_d = S_LOUT;
						end
						FUNC_RUN: state_d = S_RSTART;
						default: ;
					endcase
				end
			end
			S_LOUT: begin
				if (sts.out_free) begin
					cmd.out_lbl = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RSTART: begin
				pass_d = 8'd1;
				e_d = '0;
				cmd.lim_set = 1'b1;
				cmd.lim_zero = max_iter == 7'd0;
				state_d = (max_iter == 7'd0) ? S_EMIT : S_PSTART;
			end
			S_PSTART: begin
				cmd.acc_clear = 1'b1;
				chg_d = 1'b0;
				p_d = '0;
				state_d = (n_eff == '0) ? S_PEND : S_PREAD;
			end
			S_PREAD: begin
				cmd.pix_rd = 1'b1;
				state_d = S_PLATCH;
			end
			S_PLATCH: begin
				cmd.best_init = 1'b1;
				ci_d = '0;
				state_d = S_PDIST;
			end
			S_PDIST: begin
				cmd.dist_en = 1'b1;
				if (CLU_W'(ci_q) == k_last)
					state_d = S_PWRITE;
				else
					ci_d = ci_q + CIX_W'(1);
			end
			S_PWRITE: begin
				cmd.lbl_wr = 1'b1;
				cmd.acc_rd = 1'b1;
				// first pass: every label starts unassigned
				chg_d = chg_q || (pass_q == 8'd1) || sts.label_diff;
				state_d = S_PACC;
			end
			S_PACC: begin
				cmd.acc_wr = 1'b1;
				p_d = p_q + CNT_W'(1);
				state_d = (p_d == n_eff) ? S_PEND : S_PREAD;
			end
			S_PEND: begin
				u_d = '0;
				e_d = '0;
				state_d = chg_q ? S_UREAD : S_EMIT;
			end
			S_UREAD: begin
				cmd.acc_rd = 1'b1;
				cmd.acc_upd = 1'b1;
				state_d = S_ULOAD;
			end
			S_ULOAD: begin
				cmd.div_load = 1'b1;
				bit_d = 3'd7;
				if (sts.div_zero) begin
					// empty cluster keeps its centre
					if (u_last) begin
						pass_d = pass_q + 8'd1;
						state_d = stop_iter ? S_EMIT : S_PSTART;
					end else begin
						u_d = u_q + CIX_W'(1);
						state_d = S_UREAD;
					end
				end else begin
					state_d = S_UDIV;
				end
			end
			S_UDIV: begin
				cmd.div_step = 1'b1;
				if (bit_q == 3'd0)
					state_d = S_UWRITE;
				else
					bit_d = bit_q - 3'd1;
			end
			S_UWRITE: begin
				cmd.cen_upd = 1'b1;
				if (u_last) begin
					pass_d = pass_q + 8'd1;
					state_d = stop_iter ? S_EMIT : S_PSTART;
				end else begin
					u_d = u_q + CIX_W'(1);
					state_d = S_UREAD;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_pal = 1'b1;
					cmd.out_last = CLU_W'(e_q) == k_last;
					if (cmd.out_last)
						state_d = S_IDLE;
					else
						e_d = e_q + CIX_W'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= '0;
			ci_q <= '0;
			u_q <= '0;
			e_q <= '0;
			bit_q <= '0;
			pass_q <= 8'd1;
			chg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			p_q <= p_d;
			ci_q <= ci_d;
			u_q <= u_d;
			e_q <= e_d;
			bit_q <= bit_d;
			pass_q <= pass_d;
			chg_q <= chg_d;
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign pix_idx  = p_q[PIX_AW-1:0];
	assign cen_idx  = (state_q == S_PDIST) ? ci_q : e_q;
	assign upd_idx  = u_q;
	assign div_bit  = bit_q;
	assign pass_val = pass_q;
endmodule
`default_nettype wire

### rtl/kmeans_color_quantizer_top.sv
// Top level of the k-means colour quantizer: configuration registers,
// sequencer and datapath. Uses kcq_pkg, kcq_ctrl, kcq_datapath and the defines header.
//
//  channel  dir  handshake             payload
//  in       in   in_valid/in_ready     in_item  (func, index, red, green, blue)
//  out      out  out_valid/out_ready   out_item (kind, entry, colour, passes, last)
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data (always ready)
//
// Pixel and centre loads go straight into the stores, and the block stays ready for the next item.
// A label read goes through S_LOUT, which waits for the result register to be free.
// A run is made of Lloyd passes and centre updates, then the palette output:
// the distance unit handles one centre per cycle, the divider one quotient bit per cycle.
// No clearing pass after reset: label validity is a single limit register.
// A stalled result register holds the sequencer only where it must emit.
`default_nettype none
`include "kmeans_color_quantizer_top_defines.svh"
module kmeans_color_quantizer_top #(
	parameter int MAX_PIXELS   = kcq_pkg::DEF_MAX_PIXELS,
	parameter int MAX_CLUSTERS = kcq_pkg::DEF_MAX_CLUSTERS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire kcq_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output kcq_pkg::out_item_t      out_item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire kcq_pkg::cfg_idx_t  cfg_index,
	input  wire logic [16:0]        cfg_data
);
	import kcq_pkg::*;

	localparam int PIX_AW = $clog2(MAX_PIXELS);
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
	localparam int CIX_W  = $clog2(MAX_CLUSTERS);
	localparam int CLU_W  = $clog2(MAX_CLUSTERS + 1);

	logic [4:0]  clusters_q;
	logic [16:0] pixels_q;
	logic [6:0]  max_iter_q;
	logic [CLU_W-1:0] k_eff;
	logic [CNT_W-1:0] n_eff;

	kcq_cmd_t cmd;
	kcq_sts_t sts;
	logic [PIX_AW-1:0] pix_idx;
	logic [CIX_W-1:0]  cen_idx;
	logic [CIX_W-1:0]  upd_idx;
	logic [2:0]        div_bit;
	logic [7:0]        pass_val;

	assign cfg_ready = 1'b1;

	// user writes registers only while idle (unenforced); index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= CLUSTERS_RESET;
			pixels_q   <= PIXELS_RESET;
			max_iter_q <= ITER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CLUSTERS: clusters_q <= cfg_data[4:0];
				CFG_PIXELS:   pixels_q   <= cfg_data;
				CFG_ITER:     max_iter_q <= cfg_data[6:0];
				CFG_SPARE:    ;
				default:      ;
			endcase
		end
	end

	// saturate K into 1..MAX_CLUSTERS and n to MAX_PIXELS
	always_comb begin
		if (clusters_q == 5'd0)
			k_eff = CLU_W'(1);
		else if (32'(clusters_q) > MAX_CLUSTERS)
			k_eff = CLU_W'(MAX_CLUSTERS);
		else
			k_eff = CLU_W'(clusters_q);
		if (32'(pixels_q) > MAX_PIXELS)
			n_eff = CNT_W'(MAX_PIXELS);
		else
			n_eff = CNT_W'(pixels_q);
	end

	kcq_ctrl #(
		.MAX_PIXELS  (MAX_PIXELS),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_func (in_item.func),
		.k_eff   (k_eff),
		.n_eff   (n_eff),
		.max_iter(max_iter_q),
		.sts     (sts),
		.cmd     (cmd),
		.pix_idx (pix_idx),
		.cen_idx (cen_idx),
		.upd_idx (upd_idx),
		.div_bit (div_bit),
		.pass_val(pass_val)
	);

	kcq_datapath #(
		.MAX_PIXELS  (MAX_PIXELS),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.pix_idx  (pix_idx),
		.cen_idx  (cen_idx),
		.upd_idx  (upd_idx),
		.div_bit  (div_bit),
		.pass_val (pass_val),
		.n_eff    (n_eff),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// a run item keeps the block busy for at least the next cycle
	`KCQ_ASSERT_NXT(a_run_busy, in_valid && in_ready && in_item.func == FUNC_RUN, !in_ready)
	// label replies are single items with no colour or pass count
	`KCQ_ASSERT_IMP(a_lbl_form, out_valid && out_item.kind == KIND_LABEL, out_item.last && out_item.passes == 8'd0 && out_item.out_red == 8'd0)
endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for kmeans_color_quantizer_top: loads pixels and centres,
// runs clustering under several register settings and reads labels back.
// Depends on kcq_pkg and the RTL of the quantizer.
`default_nettype none
module tb_top;
	import kcq_pkg::*;

	localparam int NPIX   = 65536;
	localparam int NCLU   = 16;
	localparam int LIMIT  = 3000000;
	localparam int SETTLE = 40;

	// Palette and label predictor with its own copy of stores and registers
	class palette_scoreboard;
		bit [23:0] pixels [NPIX];
		bit [3:0]  labels [NPIX];
		bit        labelled [NPIX];
		bit [23:0] centres [NCLU];
		bit [4:0]  clusters_reg = CLUSTERS_RESET;
		bit [16:0] pixels_reg   = PIXELS_RESET;
		bit [6:0]  iter_reg     = ITER_RESET;
		out_item_t expected [$];
		int        mismatches = 0;

		task report(string what);
			$display("MISMATCH %s", what);
			mismatches++;
		endtask

		function void write_reg(cfg_idx_t idx, bit [16:0] data);
			case (idx)
				CFG_CLUSTERS: clusters_reg = data[4:0];
				CFG_PIXELS:   pixels_reg = data;
				CFG_ITER:     iter_reg = data[6:0];
				default: ;
			endcase
		endfunction

		function int nearest_centre(bit [23:0] rgb, int k);
			int best, bestd, d, df;
			best = 0;
			bestd = 255 * 255 * 3 + 1;
			for (int i = 0; i < k; i++) begin
				d = 0;
				for (int c = 0; c < 3; c++) begin
					df = int'(centres[i][16 - 8 * c +: 8]) - int'(rgb[16 - 8 * c +: 8]);
					d += df * df;
				end
				if (d < bestd) begin
					bestd = d;
					best = i;
				end
			end
			return best;
		endfunction

		// Lloyd passes; returns the pass counter at the end of the run
		function int cluster(int k, int n);
			int passes, id;
			bit changed;
			longint sums [NCLU][3];
			int counts [NCLU];
			for (int p = 0; p < NPIX; p++) begin
				labelled[p] = 0;
				labels[p] = 0;
			end
			passes = 1;
			while (passes <= iter_reg) begin
				changed = 0;
				for (int p = 0; p < n; p++) begin
					id = nearest_centre(pixels[p], k);
					if (!labelled[p] || labels[p] != id) begin
						labels[p] = 4'(id);
						labelled[p] = 1;
						changed = 1;
					end
				end
				if (!changed)
					break;
				for (int i = 0; i < NCLU; i++) begin
					counts[i] = 0;
					for (int c = 0; c < 3; c++)
						sums[i][c] = 0;
				end
				for (int p = 0; p < n; p++) begin
					for (int c = 0; c < 3; c++)
						sums[labels[p]][c] += pixels[p][16 - 8 * c +: 8];
					counts[labels[p]]++;
				end
				for (int i = 0; i < k; i++)
					if (counts[i] > 0)
						for (int c = 0; c < 3; c++)
							centres[i][16 - 8 * c +: 8] = 8'(sums[i][c] / counts[i]);
				passes++;
			end
			return passes;
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			int k, n, passes;
			r = '0;
			case (it.func)
				FUNC_LOAD_PIXEL:  pixels[it.index] = {it.red, it.green, it.blue};
				FUNC_LOAD_CENTER: if (it.index < NCLU) centres[it.index] = {it.red, it.green, it.blue};
				FUNC_READ_LABEL: begin
					r.kind = KIND_LABEL;
					r.entry = labelled[it.index] ? labels[it.index] : 4'd0;
					r.last = 1'b1;
					expected.insert(expected.size(), r);
				end
				default: begin
					k = clusters_reg == 0 ? 1 : (clusters_reg > NCLU ? NCLU : clusters_reg);
					n = pixels_reg > NPIX ? NPIX : pixels_reg;
					passes = cluster(k, n);
					for (int i = 0; i < k; i++) begin
						r.kind = KIND_PALETTE;
						r.entry = 4'(i);
						{r.out_red, r.out_green, r.out_blue} = centres[i];
						r.passes = 8'(passes);
						r.last = (i + 1 == k);
						expected.insert(expected.size(), r);
					end
				end
			endcase
		endfunction

		task check(out_item_t got);
			out_item_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = expected.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind %0d want %0d", got.kind, want.kind));
			if (got.entry != want.entry)
				report($sformatf("entry %0d want %0d", got.entry, want.entry));
			if (got.out_red != want.out_red)
				report($sformatf("red %0d want %0d", got.out_red, want.out_red));
			if (got.out_green != want.out_green)
				report($sformatf("green %0d want %0d", got.out_green, want.out_green));
			if (got.out_blue != want.out_blue)
				report($sformatf("blue %0d want %0d", got.out_blue, want.out_blue));
			if (got.passes != want.passes)
				report($sformatf("passes %0d want %0d", got.passes, want.passes));
			if (got.last != want.last)
				report($sformatf("last %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid, in_ready;
	in_item_t   in_item;
	logic       out_valid, out_ready;
	out_item_t  out_item;
	logic       cfg_valid, cfg_ready;
	cfg_idx_t   cfg_index;
	logic [16:0] cfg_data;

	palette_scoreboard board;
	int unsigned cycles = 0;
	int          burst_left = 0;
	int          items_sent = 0;

	kmeans_color_quantizer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Monitors: values read here are the ones before the edge took effect
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready)
			board.note_input(in_item);
		if (arst_n && cfg_valid && cfg_ready)
			board.write_reg(cfg_index, cfg_data);
		if (arst_n && out_valid && out_ready)
			board.check(out_item);
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver back-pressure in one of four stall modes, redrawn at random
	int stall_mode = 0;
	always @(posedge clk) begin
		if (cycles % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (cycles % 4 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// One item; the sender works in bursts with random gaps in between
	task send(func_t f, logic [15:0] idx, logic [23:0] rgb);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_item <= '{func: f, index: idx, red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0]};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Quiet the input and let every expected item come back
	task drain;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, logic [16:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function logic [23:0] rand_rgb;
		return 24'($urandom);
	endfunction

	// Pixels grouped round a few base colours, with some fully random ones
	task load_image(int n);
		logic [23:0] base [4];
		logic [23:0] px;
		int b;
		for (int i = 0; i < 4; i++)
			base[i] = rand_rgb();
		for (int p = 0; p < n; p++) begin
			b = $urandom_range(0, 3);
			px = base[b];
			if ($urandom_range(0, 5) == 0)
				px = rand_rgb();
			else
				for (int c = 0; c < 3; c++)
					px[8 * c +: 8] = px[8 * c +: 8] ^ 8'($urandom_range(0, 15));
			send(FUNC_LOAD_PIXEL, 16'(p), px);
		end
	endtask

	task load_centres;
		for (int i = 0; i < NCLU; i++)
			send(FUNC_LOAD_CENTER, 16'(i), rand_rgb());
	endtask

	// Settings change only once the block is idle
	task clustering_phase(logic [4:0] k, logic [16:0] n, logic [6:0] it, int reads);
		drain();
		write_reg(CFG_CLUSTERS, k);
		write_reg(CFG_PIXELS, n);
		write_reg(CFG_ITER, it);
		load_image(n);
		load_centres();
		if ($urandom_range(0, 1))
			send(FUNC_LOAD_CENTER, 16'($urandom_range(NCLU, 65535)), rand_rgb());
		send(FUNC_RUN, 16'($urandom), rand_rgb());
		for (int i = 0; i < reads; i++)
			if ($urandom_range(0, 3) == 0)
				send(FUNC_READ_LABEL, 16'($urandom), rand_rgb());
			else
				send(FUNC_READ_LABEL, 16'($urandom_range(0, n)), rand_rgb());
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CLUSTERS;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read before any run, top pixel address, colour extremes
		send(FUNC_READ_LABEL, 16'hFFFF, 24'h000000);
		send(FUNC_LOAD_PIXEL, 16'hFFFF, 24'hFFFFFF);
		drain();
		write_reg(CFG_CLUSTERS, 5'd4);
		write_reg(CFG_PIXELS, 17'd4);
		write_reg(CFG_ITER, 7'd100);
		send(FUNC_LOAD_PIXEL, 16'd0, 24'h000000);
		send(FUNC_LOAD_PIXEL, 16'd1, 24'hFFFFFF);
		send(FUNC_LOAD_PIXEL, 16'd2, 24'hFF00FF);
		send(FUNC_LOAD_PIXEL, 16'd3, 24'h00FF00);
		// two pairs of equal centres: ties go low, so centre 3 stays empty
		send(FUNC_LOAD_CENTER, 16'd0, 24'h808080);
		send(FUNC_LOAD_CENTER, 16'd1, 24'h808080);
		send(FUNC_LOAD_CENTER, 16'd2, 24'h000000);
		send(FUNC_LOAD_CENTER, 16'd3, 24'h000000);
		for (int i = 4; i < NCLU; i++)
			send(FUNC_LOAD_CENTER, 16'(i), rand_rgb());
		send(FUNC_LOAD_CENTER, 16'hFFFF, 24'hFFFFFF);
		send(FUNC_RUN, 16'd0, 24'd0);
		send(FUNC_READ_LABEL, 16'd0, 24'd0);
		send(FUNC_READ_LABEL, 16'd3, 24'd0);
		send(FUNC_READ_LABEL, 16'd4, 24'd0);
		send(FUNC_READ_LABEL, 16'hFFFF, 24'hFFFFFF);

		// Register extremes: zero / oversized cluster count, no pixels, no passes
		clustering_phase(5'd0, 17'd6, 7'd5, 3);
		clustering_phase(5'd31, 17'd40, 7'd127, 4);
		clustering_phase(5'd16, 17'd12, 7'd0, 3);
		clustering_phase(5'd3, 17'd0, 7'd10, 2);
		clustering_phase(5'd1, 17'd1, 7'd1, 2);

		// Random phases
		while (items_sent < 220) begin
			clustering_phase($urandom_range(0, 5) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)),
				17'($urandom_range(0, 48)),
				$urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 3)) : 7'($urandom_range(1, 127)),
				$urandom_range(3, 10));
		end

		drain();
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
